FILE: rtl/sorted_table_bound_search_top_assert.svh
// Assertion macros shared by the bound search checker.
`ifndef SORTED_TABLE_BOUND_SEARCH_TOP_ASSERT_SVH
`define SORTED_TABLE_BOUND_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bound search port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bound search port check failed");

`endif

FILE: rtl/stbs_pkg.sv
// Shared types and constants for the sorted table bound search block.
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int CMD_W = 2;
    localparam int IDX_W = 10;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_LOWER = 2'd1,
        CMD_UPPER = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST_RD,
        S_FIRST_CMP,
        S_MID,
        S_STEP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic wr;
        logic load;
        logic rd_first;
        logic init;
        logic rd_mid;
        logic go_right;
        logic go_left;
        logic fin_none;
        logic fin_first;
        logic fin_mid;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic len_zero;
        logic first_hit;
        logic range_empty;
        logic mid_out;
        logic step_right;
        logic step_left;
        logic left_dead;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/stbs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = stbs_pkg::KEY_WIDTH_DEF,
    parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

FILE: rtl/stbs_ctrl.sv
// Sequencing state machine for writes and bisection searches.
`default_nettype none

module stbs_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [stbs_pkg::CMD_W-1:0] i_cmd,
    input  wire stbs_pkg::t_dp_status      i_status,
    output stbs_pkg::t_dp_cmd              o_cmd,
    output logic                           o_busy
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != stbs_pkg::S_IDLE);
        unique case (r_state)
            stbs_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        stbs_pkg::CMD_WRITE: begin
                            o_cmd.wr = 1'b1;
                        end
                        stbs_pkg::CMD_LOWER, stbs_pkg::CMD_UPPER: begin
                            o_cmd.load = 1'b1;
                            n_state    = stbs_pkg::S_FIRST_RD;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            stbs_pkg::S_FIRST_RD: begin
                if (i_status.len_zero) begin
                    o_cmd.fin_none = 1'b1;
                    n_state        = stbs_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = stbs_pkg::S_FIRST_CMP;
                end
            end
            stbs_pkg::S_FIRST_CMP: begin
                if (i_status.first_hit) begin
                    o_cmd.fin_first = 1'b1;
                    n_state         = stbs_pkg::S_IDLE;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = stbs_pkg::S_MID;
                end
            end
            stbs_pkg::S_MID: begin
                if (i_status.range_empty || i_status.mid_out) begin
                    o_cmd.fin_none = 1'b1;
                    n_state        = stbs_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_mid = 1'b1;
                    n_state      = stbs_pkg::S_STEP;
                end
            end
            stbs_pkg::S_STEP: begin
                priority if (i_status.step_right) begin
                    o_cmd.go_right = 1'b1;
                    n_state        = stbs_pkg::S_MID;
                end else if (i_status.step_left && i_status.left_dead) begin
                    o_cmd.fin_none = 1'b1;
                    n_state        = stbs_pkg::S_IDLE;
                end else if (i_status.step_left) begin
                    o_cmd.go_left = 1'b1;
                    n_state       = stbs_pkg::S_MID;
                end else begin
                    o_cmd.fin_mid = 1'b1;
                    n_state       = stbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/stbs_dp.sv
// Datapath: length register, key table, bisection bounds and result register.
`default_nettype none

module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire stbs_pkg::t_dp_cmd          i_cmd,
    output stbs_pkg::t_dp_status            o_status,
    input  wire logic                       i_cfg_we,
    input  wire logic [stbs_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic [stbs_pkg::CMD_W-1:0] i_op,
    input  wire logic [stbs_pkg::IDX_W-1:0] i_entry_index,
    input  wire logic [KEY_WIDTH-1:0]       i_key,
    output logic                            o_valid,
    output logic                            o_found,
    output logic      [stbs_pkg::POS_W-1:0] o_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (AW > stbs_pkg::IDX_W) ? AW : stbs_pkg::IDX_W;
    localparam int MW = (LW > stbs_pkg::CFG_W) ? LW : stbs_pkg::CFG_W;

    logic [stbs_pkg::CFG_W-1:0] r_table_length;
    logic [KEY_WIDTH-1:0]       r_key;
    logic                       r_upper;
    logic [LW-1:0]              r_len;
    logic [LW-1:0]              r_lo;
    logic [LW-1:0]              r_hi;
    logic [LW-1:0]              r_m;
    logic                       r_valid;
    logic                       r_found;
    logic [stbs_pkg::POS_W-1:0] r_pos;

    logic [IW:0]          idx_ext;
    logic                 idx_ok;
    logic [MW-1:0]        len_cfg;
    logic [LW-1:0]        len_sat;
    logic [LW:0]          sum;
    logic [LW-1:0]        m_raw;
    logic [LW-1:0]        m_sel;
    logic [LW:0]          m_inc;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    logic [KEY_WIDTH-1:0] rdata_a;
    logic [KEY_WIDTH-1:0] rdata_b;
    logic signed [KEY_WIDTH-1:0] key_s;
    logic signed [KEY_WIDTH-1:0] a_s;
    logic signed [KEY_WIDTH-1:0] b_s;

    // write index range check and length saturation
    assign idx_ext = (IW+1)'(i_entry_index);
    assign idx_ok  = idx_ext < (IW+1)'(TABLE_DEPTH);
    assign len_cfg = MW'(r_table_length);
    assign len_sat = (len_cfg > MW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(len_cfg);

    // floor midpoint, clamped to 1 for lower bound
    assign sum   = (LW+1)'(r_lo) + (LW+1)'(r_hi);
    assign m_raw = LW'(sum >> 1);
    assign m_sel = (!r_upper && (m_raw == '0)) ? LW'(1) : m_raw;
    assign m_inc = (LW+1)'(m_sel) + (LW+1)'(1);

    always_comb begin
        if (i_cmd.rd_first) begin
            raddr_a = r_upper ? AW'(r_len - LW'(1)) : '0;
            raddr_b = '0;
        end else if (r_upper) begin
            raddr_a = AW'(m_sel);
            raddr_b = AW'(m_inc);
        end else begin
            raddr_a = AW'(m_sel - LW'(1));
            raddr_b = AW'(m_sel);
        end
    end

    stbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.wr && idx_ok),
        .i_waddr   (AW'(idx_ext)),
        .i_wdata   (i_key),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign key_s = $signed(r_key);
    assign a_s   = $signed(rdata_a);
    assign b_s   = $signed(rdata_b);

    always_comb begin
        o_status.len_zero    = (r_len == '0);
        o_status.first_hit   = r_upper ? (a_s <= key_s) : (a_s >= key_s);
        o_status.range_empty = (r_lo > r_hi);
        o_status.mid_out     = r_upper ? (m_inc >= (LW+1)'(r_len)) : (m_sel >= r_len);
        if (r_upper) begin
            o_status.step_right = (a_s <= key_s) && (b_s <= key_s);
            o_status.step_left  = (key_s < a_s) && (key_s < b_s);
        end else begin
            o_status.step_right = (a_s < key_s) && (b_s < key_s);
            o_status.step_left  = (key_s <= a_s) && (key_s <= b_s);
        end
        o_status.left_dead = (r_m == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_length <= i_cfg_wdata;
            end
            r_valid <= i_cmd.fin_none || i_cmd.fin_first || i_cmd.fin_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_upper <= (i_op == stbs_pkg::CMD_UPPER);
            r_len   <= len_sat;
        end
        if (i_cmd.init) begin
            r_lo <= '0;
            r_hi <= r_len - LW'(1);
        end
        if (i_cmd.rd_mid) begin
            r_m <= m_sel;
        end
        if (i_cmd.go_right) begin
            r_lo <= r_m + LW'(1);
        end
        if (i_cmd.go_left) begin
            r_hi <= r_m - LW'(1);
        end
        if (i_cmd.fin_none) begin
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.fin_first) begin
            r_found <= 1'b1;
            r_pos   <= r_upper ? stbs_pkg::POS_W'(r_len - LW'(1)) : '0;
        end
        if (i_cmd.fin_mid) begin
            r_found <= 1'b1;
            r_pos   <= stbs_pkg::POS_W'(r_m);
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

`default_nettype wire

FILE: rtl/sorted_table_bound_search_top.sv
// Top level of the sorted table bound search block.
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------
//  command   start / busy              i_cmd, i_entry_index, i_key
//  result    o_valid (one-cycle pulse) o_found, o_position
//  config    i_cfg_we                  i_cfg_wdata (table_length)
//
// A write transfer gives no result; busy stays low.
// A search on an empty table ends in the first-read state; otherwise the
// boundary entry is read and compared, and a hit ends it there. Each bisection
// step then reads the midpoint pair and compares it, as the key RAM read is
// registered; a search ends on a compare hit, a left step from position zero,
// crossed bounds, or a midpoint that runs past the length.
// Reset (i_rst_n low, synchronous) clears the FSM, the length register and
// the result pulse; table contents are undefined until written.
// Results cannot be stalled; the next command can transfer in the cycle the
// result pulse is shown.
`default_nettype none

module sorted_table_bound_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command channel
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [stbs_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [stbs_pkg::IDX_W-1:0] i_entry_index,
    input  wire logic [KEY_WIDTH-1:0]       i_key,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [stbs_pkg::CFG_W-1:0] i_cfg_wdata,
    // result channel
    output logic                            o_valid,
    output logic                            o_found,
    output logic      [stbs_pkg::POS_W-1:0] o_position
);

    stbs_pkg::t_dp_cmd    dp_cmd;
    stbs_pkg::t_dp_status dp_status;

    // controller: sequences the boundary check and each bisection step
    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // datapath: key RAM, bounds, midpoint, compares and result register
    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_cmd),
        .i_entry_index (i_entry_index),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule

`default_nettype wire

FILE: rtl/stbs_chk.sv
// Port-level checker for the bound search block, bound to the top level.
`default_nettype none

`include "sorted_table_bound_search_top_assert.svh"

module stbs_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [stbs_pkg::CMD_W-1:0] i_cmd,
    input wire logic                       o_valid,
    input wire logic                       o_found,
    input wire logic [stbs_pkg::POS_W-1:0] o_position
);

    // not found always reports position zero
    `STBS_ASSERT_NOW(a_nf_pos_zero, i_clk, i_rst_n, o_valid && !o_found, o_position == '0)

    // a result only ends a busy search
    `STBS_ASSERT_NOW(a_res_after_busy, i_clk, i_rst_n, o_valid, $past(busy))

    // a write transfer never yields a result
    `STBS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n,
        start && !busy && (i_cmd == stbs_pkg::CMD_WRITE), !o_valid)

    // a search transfer makes the block busy, with no result yet
    `STBS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        start && !busy && (i_cmd == stbs_pkg::CMD_LOWER || i_cmd == stbs_pkg::CMD_UPPER),
        busy && !o_valid)

endmodule

bind sorted_table_bound_search_top stbs_chk u_stbs_chk (.*);

`default_nettype wire

FILE: test/sorted_table_bound_search_top_test.sv
// Self-checking testbench for the sorted table bound search block.
module sorted_table_bound_search_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W      = stbs_pkg::KEY_WIDTH_DEF;
    localparam int DEPTH      = stbs_pkg::TABLE_DEPTH_DEF;
    // Leave plenty of margin after the longest search before touching the
    // length register.
    localparam int SETTLE_CYCLES = 40;
    // Random part stops once this many transfers (directed ones included)
    // have gone through; the large-table and saturation phases follow.
    localparam int RANDOM_TARGET = 540;
    localparam int LARGE_TABLE   = 200;

    // Command code 3 has no enum member; the block must drop it silently.
    localparam logic [stbs_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic                       found;
        logic [stbs_pkg::POS_W-1:0] position;
    } t_bound_result;

    // One row of the directed table: either a length register write or a
    // command transfer, optionally with a hand-derived expected result.
    typedef struct packed {
        bit                         is_cfg;
        logic [stbs_pkg::CFG_W-1:0] length;
        logic [stbs_pkg::CMD_W-1:0] cmd;
        logic [stbs_pkg::IDX_W-1:0] idx;
        logic signed [KEY_W-1:0]    key;
        bit                         typed;
        logic                       found;
        logic [stbs_pkg::POS_W-1:0] position;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 26;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // length 0 after reset: any search misses, spare code is dropped
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, KEY_MIN, 1'b1, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, KEY_MAX, 1'b1, 1'b0, '0},
        '{1'b0, '0, CMD_SPARE, 10'd1023, -32'sd1, 1'b0, 1'b0, '0},
        // a sorted four-entry table spanning the key extremes
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd0, KEY_MIN, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd1, -32'sd5, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd2, 32'sd7, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd3, KEY_MAX, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd1023, -32'sd1, 1'b0, 1'b0, '0},
        // one entry: lower search past the first entry runs off the end
        '{1'b1, 11'd1, stbs_pkg::CMD_WRITE, '0, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, KEY_MIN, 1'b1, 1'b1, 10'd0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, 32'sd0, 1'b1, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, KEY_MAX, 1'b1, 1'b1, 10'd0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, KEY_MIN, 1'b1, 1'b1, 10'd0},
        // four entries: boundary hits and real bisection
        '{1'b1, 11'd4, stbs_pkg::CMD_WRITE, '0, '0, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, KEY_MIN, 1'b1, 1'b1, 10'd0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, -32'sd5, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, 32'sd8, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, KEY_MAX, 1'b1, 1'b1, 10'd3},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, 32'sd0, 1'b0, 1'b0, '0},
        // upper miss: key below the first entry
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd0, -32'sd100, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, KEY_MIN, 1'b0, 1'b0, '0},
        // lower miss: every entry below the key
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd3, 32'sd100, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, KEY_MAX, 1'b0, 1'b0, '0},
        // out-of-order table
        '{1'b0, '0, stbs_pkg::CMD_WRITE, 10'd1, 32'sd50, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_UPPER, '0, 32'sd60, 1'b0, 1'b0, '0},
        '{1'b0, '0, stbs_pkg::CMD_LOWER, '0, 32'sd49, 1'b0, 1'b0, '0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [stbs_pkg::CMD_W-1:0] i_cmd;
    logic [stbs_pkg::IDX_W-1:0] i_entry_index;
    logic [KEY_W-1:0]           i_key;
    logic                       i_cfg_we;
    logic [stbs_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                       o_valid;
    logic                       o_found;
    logic [stbs_pkg::POS_W-1:0] o_position;

    // Shadow copy of the block: table contents and the length register.
    logic signed [KEY_W-1:0] key_table [DEPTH];
    int unsigned             table_len;

    t_bound_result bound_results_due[$];

    bit no_gaps;
    int error_count;
    int items_sent;
    int search_count;
    int write_count;
    int hit_count;
    int length_writes;

    sorted_table_bound_search_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .i_key         (i_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_position    (o_position)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Length register saturates at the table depth.
    function automatic int used_entries();
        return (table_len > DEPTH) ? DEPTH : int'(table_len);
    endfunction

    // Lower bound: first position whose entry is not below the key.
    // Midpoint is floored and clamped to 1 so entry m-1 always exists.
    function automatic int lower_bound_of(input logic signed [KEY_W-1:0] v);
        int n;
        int lo;
        int hi;
        int m;
        logic signed [KEY_W-1:0] a;
        logic signed [KEY_W-1:0] b;
        n = used_entries();
        if (n < 1) return -1;
        if (key_table[0] >= v) return 0;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            m = (lo + hi) / 2;
            if (m < 1) m = 1;
            if (m >= n) return -1;
            a = key_table[m-1];
            b = key_table[m];
            if (a < v && b < v) lo = m + 1;
            else if (v <= a && v <= b) hi = m - 1;
            else return m;
        end
        return -1;
    endfunction

    // Upper bound: last position whose entry is not above the key.
    function automatic int upper_bound_of(input logic signed [KEY_W-1:0] v);
        int n;
        int lo;
        int hi;
        int m;
        logic signed [KEY_W-1:0] a;
        logic signed [KEY_W-1:0] b;
        n = used_entries();
        if (n < 1) return -1;
        if (key_table[n-1] <= v) return n - 1;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            m = (lo + hi) / 2;
            if (m + 1 >= n) return -1;
            a = key_table[m];
            b = key_table[m+1];
            if (a <= v && b <= v) lo = m + 1;
            else if (v < a && v < b) hi = m - 1;
            else return m;
        end
        return -1;
    endfunction

    // Search keys mostly land on or next to stored entries so that the
    // bisection ends on a hit; the rest are extremes and full-range noise.
    function automatic logic signed [KEY_W-1:0] search_key(input int n);
        int pick;
        logic signed [KEY_W-1:0] near;
        pick = $urandom_range(0, 9);
        if (n == 0 || pick >= 8) return $urandom;
        near = key_table[$urandom_range(0, n - 1)];
        if (pick <= 3) return near;
        if (pick <= 5) return near + $urandom_range(0, 6) - 3;
        return pick[0] ? KEY_MAX : KEY_MIN;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // One command transfer. Inputs move on the falling edge; the transfer
    // happens at the first rising edge where start is high and busy low.
    // With no gap, start simply stays high into the next command.
    task automatic issue_command(input logic [stbs_pkg::CMD_W-1:0] cmd,
                                 input logic [stbs_pkg::IDX_W-1:0] idx,
                                 input logic signed [KEY_W-1:0] key,
                                 input bit predict);
        int gap;
        int pos;
        t_bound_result res;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_entry_index <= idx;
        i_key         <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
        case (cmd)
            stbs_pkg::CMD_WRITE: begin
                key_table[idx] = key;
                write_count++;
            end
            stbs_pkg::CMD_LOWER, stbs_pkg::CMD_UPPER: begin
                search_count++;
                if (predict) begin
                    pos = (cmd == stbs_pkg::CMD_LOWER) ? lower_bound_of(key)
                                                       : upper_bound_of(key);
                    res.found    = (pos >= 0);
                    res.position = (pos >= 0) ? pos[stbs_pkg::POS_W-1:0] : '0;
                    bound_results_due.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    // Drop start, wait for every outstanding result, then let any
    // in-flight work finish before the block is considered idle.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (bound_results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_table_length(input int unsigned len);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len[stbs_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        table_len = len;
        length_writes++;
    endtask

    // Write positions 0..n-1 in ascending order: either spread over the
    // whole key range, or packed tightly with frequent duplicates.
    task automatic fill_ascending(input int n);
        longint cur;
        longint stride;
        int k;
        bit spread;
        spread = $urandom_range(0, 1);
        stride = 64'd4294967295 / (n + 1);
        if (spread) begin
            cur = longint'(KEY_MIN) + longint'($urandom_range(0, stride));
        end else begin
            cur = longint'($signed($urandom));
            if (cur > longint'(KEY_MAX) - 4 * n) cur = longint'(KEY_MAX) - 4 * n;
        end
        for (k = 0; k < n; k++) begin
            issue_command(stbs_pkg::CMD_WRITE, k[stbs_pkg::IDX_W-1:0], cur[KEY_W-1:0],
                          1'b1);
            cur += longint'(spread ? $urandom_range(0, stride) : $urandom_range(0, 3));
        end
    endtask

    // Mostly searches against the current table; a few stray writes that
    // may break the ordering, and a few spare-code commands.
    task automatic exercise_table(input int count);
        int n;
        int k;
        int pick;
        n = used_entries();
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                issue_command(CMD_SPARE, $urandom, $urandom, 1'b1);
            end else if (pick == 1) begin
                issue_command(stbs_pkg::CMD_WRITE,
                              (n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1)
                                                              : $urandom_range(0, DEPTH - 1),
                              $urandom, 1'b1);
            end else begin
                issue_command(pick[0] ? stbs_pkg::CMD_LOWER : stbs_pkg::CMD_UPPER, $urandom,
                              search_key(n), 1'b1);
            end
        end
    endtask

    // Saturated or full length: only the first and last entries are read.
    task automatic probe_ends(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            issue_command(stbs_pkg::CMD_LOWER, $urandom, KEY_MIN, 1'b1);
            issue_command(stbs_pkg::CMD_UPPER, $urandom, KEY_MAX, 1'b1);
        end
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_bound_result due;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (bound_results_due.size() == 0) begin
                note_failure($sformatf("unexpected result found=%0b position=%0d",
                                       o_found, o_position));
            end else begin
                due = bound_results_due.pop_front();
                if (o_found !== due.found || o_position !== due.position)
                    note_failure($sformatf({"expected found=%0b position=%0d, ",
                                            "got found=%0b position=%0d"},
                                           due.found, due.position, o_found, o_position));
                if (o_found === 1'b1) hit_count++;
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int r;
        int n;
        t_bound_result typed_res;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = stbs_pkg::CMD_WRITE;
        i_entry_index = '0;
        i_key         = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        table_len     = 0;
        no_gaps       = 1'b0;
        foreach (key_table[k]) key_table[k] = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: rows with a hand-derived answer queue it directly,
        // the rest go through the shadow model.
        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].is_cfg) begin
                set_table_length(DIRECTED[k].length);
            end else begin
                issue_command(DIRECTED[k].cmd, DIRECTED[k].idx, DIRECTED[k].key,
                              !DIRECTED[k].typed);
                if (DIRECTED[k].typed &&
                    (DIRECTED[k].cmd == stbs_pkg::CMD_LOWER ||
                     DIRECTED[k].cmd == stbs_pkg::CMD_UPPER)) begin
                    typed_res.found    = DIRECTED[k].found;
                    typed_res.position = DIRECTED[k].position;
                    bound_results_due.push_back(typed_res);
                end
            end
        end

        // Random phases on small tables: fill sorted, set the length,
        // then hammer it. Some phases run with no idle cycles at all.
        while (items_sent < RANDOM_TARGET) begin
            r = $urandom_range(0, 9);
            n = (r <= 2) ? r : $urandom_range(3, 48);
            no_gaps = ($urandom_range(0, 3) == 0);
            fill_ascending(n);
            set_table_length(n);
            exercise_table($urandom_range(15, 40));
        end

        // One larger table, then a partial length over the same contents.
        no_gaps = 1'b0;
        fill_ascending(LARGE_TABLE);
        set_table_length(LARGE_TABLE);
        exercise_table(40);
        set_table_length($urandom_range(LARGE_TABLE / 2, LARGE_TABLE - 1));
        exercise_table(30);

        // Full depth and the saturating length code, with the last entry set.
        issue_command(stbs_pkg::CMD_WRITE, '1, KEY_MAX, 1'b1);
        set_table_length(DEPTH);
        probe_ends(2);
        set_table_length((1 << stbs_pkg::CFG_W) - 1);
        probe_ends(2);

        settle();
        $display("Run covered %0d transfers: %0d searches (%0d hits), %0d entry writes,",
                 items_sent, search_count, hit_count, write_count);
        $display("and %0d length register writes from empty to saturated.", length_writes);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
